FILE: rtl/cbr_pkg.sv
// cbr_pkg: shared types, constants and microcode ROM of the cubic bisection root finder.
// Depends on nothing; used by every module under rtl.
package cbr_pkg;

    localparam int MAX_STEPS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int STEP_W    = 6;
    localparam int LIMB_W    = 32;
    localparam int WIDE_W    = 128;
    localparam int PROD_W    = LIMB_W + 1 + DATA_W;
    localparam int PC_W      = 4;
    localparam int IDX_W     = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

    typedef logic [PC_W-1:0]          pc_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [1:0]               sign_t;
    typedef logic [IDX_W-1:0]         reg_idx_t;

    localparam sign_t SGN_ZERO = 2'd0;
    localparam sign_t SGN_POS  = 2'd1;
    localparam sign_t SGN_NEG  = 2'd3;

    localparam logic [1:0] ST_EXACT      = 2'd0;
    localparam logic [1:0] ST_CONVERGED  = 2'd1;
    localparam logic [1:0] ST_NO_BRACKET = 2'd2;
    localparam logic [1:0] ST_STEP_LIMIT = 2'd3;

    localparam reg_idx_t REG_CUBIC    = 3'd0;
    localparam reg_idx_t REG_SQUARE   = 3'd1;
    localparam reg_idx_t REG_LINEAR   = 3'd2;
    localparam reg_idx_t REG_CONSTANT = 3'd3;
    localparam reg_idx_t REG_TOL      = 3'd4;

    localparam pc_t PC_IDLE  = 4'd0;
    localparam pc_t PC_LEFT  = 4'd1;
    localparam pc_t PC_RIGHT = 4'd2;
    localparam pc_t PC_ENDS  = 4'd3;
    localparam pc_t PC_LOOP  = 4'd4;
    localparam pc_t PC_MID   = 4'd5;
    localparam pc_t PC_EVAL  = 4'd6;
    localparam pc_t PC_E1    = 4'd7;
    localparam pc_t PC_E2    = 4'd8;
    localparam pc_t PC_E3    = 4'd9;
    localparam pc_t PC_E4    = 4'd10;
    localparam pc_t PC_E5    = 4'd11;
    localparam pc_t PC_E6    = 4'd12;
    localparam pc_t PC_E7    = 4'd13;
    localparam pc_t PC_E8    = 4'd14;
    localparam pc_t PC_E9    = 4'd15;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_WAIT,
        SEQ_JUMP,
        SEQ_CALL,
        SEQ_RET
    } seq_op_t;

    typedef enum logic [1:0] {
        X_KEEP,
        X_LEFT,
        X_RIGHT,
        X_MID
    } x_op_t;

    typedef enum logic [1:0] {
        ADD_C2,
        ADD_C1,
        ADD_C0
    } addend_t;

    typedef enum logic [2:0] {
        T_NONE,
        T_SIGN_LEFT,
        T_ENDS,
        T_LOOP,
        T_MID
    } task_op_t;

    typedef struct packed {
        seq_op_t    seq;
        pc_t        target;
        x_op_t      x_op;
        logic       h_init;
        logic       pacc_ld;
        addend_t    addend;
        logic       mul_en;
        logic [1:0] mul_limb;
        logic       mul_signed;
        logic       acc_en;
        logic [1:0] acc_limb;
        logic       fin;
        task_op_t   op;
    } ucode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] c3;
        logic signed [DATA_W-1:0] c2;
        logic signed [DATA_W-1:0] c1;
        logic signed [DATA_W-1:0] c0;
    } coef_t;

    // Horner: h=c3; h=h*x+c2; h=h*x+c1; h=h*x+c0, at most one 33x32 partial product per step
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        begin
            w = '0;
            unique case (pc)
                PC_IDLE:
                begin
                    w.seq = SEQ_WAIT;
                end
                PC_LEFT:
                begin
                    w.x_op   = X_LEFT;
                    w.seq    = SEQ_CALL;
                    w.target = PC_EVAL;
                end
                PC_RIGHT:
                begin
                    w.op     = T_SIGN_LEFT;
                    w.x_op   = X_RIGHT;
                    w.seq    = SEQ_CALL;
                    w.target = PC_EVAL;
                end
                PC_ENDS:
                begin
                    w.op  = T_ENDS;
                    w.seq = SEQ_NEXT;
                end
                PC_LOOP:
                begin
                    w.op     = T_LOOP;
                    w.x_op   = X_MID;
                    w.seq    = SEQ_CALL;
                    w.target = PC_EVAL;
                end
                PC_MID:
                begin
                    w.op     = T_MID;
                    w.seq    = SEQ_JUMP;
                    w.target = PC_LOOP;
                end
                PC_EVAL:
                begin
                    w.h_init  = 1'b1;
                    w.pacc_ld = 1'b1;
                    w.addend  = ADD_C2;
                end
                PC_E1:
                begin
                    w.mul_en     = 1'b1;
                    w.mul_limb   = 2'd0;
                    w.mul_signed = 1'b1;
                end
                PC_E2:
                begin
                    w.acc_en   = 1'b1;
                    w.acc_limb = 2'd0;
                    w.fin      = 1'b1;
                    w.pacc_ld  = 1'b1;
                    w.addend   = ADD_C1;
                end
                PC_E3:
                begin
                    w.mul_en   = 1'b1;
                    w.mul_limb = 2'd0;
                end
                PC_E4:
                begin
                    w.mul_en     = 1'b1;
                    w.mul_limb   = 2'd1;
                    w.mul_signed = 1'b1;
                    w.acc_en     = 1'b1;
                    w.acc_limb   = 2'd0;
                end
                PC_E5:
                begin
                    w.acc_en   = 1'b1;
                    w.acc_limb = 2'd1;
                    w.fin      = 1'b1;
                    w.pacc_ld  = 1'b1;
                    w.addend   = ADD_C0;
                end
                PC_E6:
                begin
                    w.mul_en   = 1'b1;
                    w.mul_limb = 2'd0;
                end
                PC_E7:
                begin
                    w.mul_en   = 1'b1;
                    w.mul_limb = 2'd1;
                    w.acc_en   = 1'b1;
                    w.acc_limb = 2'd0;
                end
                PC_E8:
                begin
                    w.mul_en     = 1'b1;
                    w.mul_limb   = 2'd2;
                    w.mul_signed = 1'b1;
                    w.acc_en     = 1'b1;
                    w.acc_limb   = 2'd1;
                end
                PC_E9:
                begin
                    w.acc_en   = 1'b1;
                    w.acc_limb = 2'd2;
                    w.fin      = 1'b1;
                    w.seq      = SEQ_RET;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/cbr_sequencer.sv
// cbr_sequencer: microcode program counter, return register and microcode ROM lookup.
// Depends on cbr_pkg.
module cbr_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            done_req,
    output cbr_pkg::ucode_t ctrl,
    output logic            busy
);

    cbr_pkg::pc_t pc_reg;
    cbr_pkg::pc_t pc_next;
    cbr_pkg::pc_t ret_reg;
    cbr_pkg::pc_t ret_next;

    assign ctrl = cbr_pkg::ucode_rom(pc_reg);
    assign busy = (pc_reg != cbr_pkg::PC_IDLE);

    always_comb
    begin
        pc_next  = pc_reg + cbr_pkg::pc_t'(1);
        ret_next = ret_reg;
        priority if (done_req)
        begin
            pc_next = cbr_pkg::PC_IDLE;
        end
        else
        begin
            unique case (ctrl.seq)
                cbr_pkg::SEQ_NEXT: pc_next = pc_reg + cbr_pkg::pc_t'(1);
                cbr_pkg::SEQ_WAIT: pc_next = accept ? cbr_pkg::PC_LEFT : cbr_pkg::PC_IDLE;
                cbr_pkg::SEQ_JUMP: pc_next = ctrl.target;
                cbr_pkg::SEQ_CALL:
                begin
                    pc_next  = ctrl.target;
                    ret_next = pc_reg + cbr_pkg::pc_t'(1);
                end
                cbr_pkg::SEQ_RET:  pc_next = ret_reg;
                default:           pc_next = cbr_pkg::PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= cbr_pkg::PC_IDLE;
            ret_reg <= cbr_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

FILE: rtl/cbr_horner.sv
// cbr_horner: exact 128-bit Horner datapath, at most one 33x32 partial product per beat.
// Depends on cbr_pkg.
module cbr_horner (
    input  logic                              clk,
    input  cbr_pkg::ucode_t                   ctrl,
    input  cbr_pkg::coef_t                    coef,
    input  logic signed [cbr_pkg::DATA_W-1:0] x,
    output cbr_pkg::sign_t                    sign
);

    cbr_pkg::wide_t                    h_reg;
    cbr_pkg::wide_t                    pacc_reg;
    logic signed [cbr_pkg::PROD_W-1:0] prod_reg;

    logic [cbr_pkg::LIMB_W-1:0]        limb;
    logic signed [cbr_pkg::LIMB_W:0]   mul_a;
    logic signed [cbr_pkg::PROD_W-1:0] prod_next;
    cbr_pkg::wide_t                    sum;
    cbr_pkg::wide_t                    addend;

    assign limb      = h_reg[cbr_pkg::LIMB_W*ctrl.mul_limb +: cbr_pkg::LIMB_W];
    assign mul_a     = {ctrl.mul_signed & limb[cbr_pkg::LIMB_W-1], limb};
    assign prod_next = mul_a * x;
    assign sum       = pacc_reg
                     + (cbr_pkg::wide_t'(prod_reg) <<< (cbr_pkg::LIMB_W * ctrl.acc_limb));

    always_comb
    begin
        unique case (ctrl.addend)
            cbr_pkg::ADD_C2: addend = cbr_pkg::wide_t'(coef.c2) <<< cbr_pkg::FRAC_BITS;
            cbr_pkg::ADD_C1: addend = cbr_pkg::wide_t'(coef.c1) <<< (2 * cbr_pkg::FRAC_BITS);
            cbr_pkg::ADD_C0: addend = cbr_pkg::wide_t'(coef.c0) <<< (3 * cbr_pkg::FRAC_BITS);
            default:         addend = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.h_init)
        begin
            h_reg <= cbr_pkg::wide_t'(coef.c3);
        end
        else if (ctrl.fin)
        begin
            h_reg <= sum;
        end
        if (ctrl.pacc_ld)
        begin
            pacc_reg <= addend;
        end
        else if (ctrl.acc_en)
        begin
            pacc_reg <= sum;
        end
    end

    assign sign = h_reg[cbr_pkg::WIDE_W-1] ? cbr_pkg::SGN_NEG
                : (h_reg == '0)           ? cbr_pkg::SGN_ZERO
                                          : cbr_pkg::SGN_POS;

endmodule

FILE: rtl/cbr_bisect.sv
// cbr_bisect: interval registers, bracket and stop decisions, result registers.
// Depends on cbr_pkg.
module cbr_bisect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [cbr_pkg::DATA_W-1:0] interval_low,
    input  logic signed [cbr_pkg::DATA_W-1:0] interval_high,
    input  cbr_pkg::ucode_t                   ctrl,
    input  cbr_pkg::sign_t                    sign,
    input  logic [cbr_pkg::TOL_W-1:0]         tolerance,
    output logic signed [cbr_pkg::DATA_W-1:0] x,
    output logic                              done_req,
    output logic                              done,
    output logic signed [cbr_pkg::DATA_W-1:0] root,
    output logic [1:0]                        status,
    output logic [cbr_pkg::STEP_W-1:0]        steps_taken
);

    function automatic logic signed [cbr_pkg::DATA_W-1:0] mid_of(
        input logic signed [cbr_pkg::DATA_W-1:0] a,
        input logic signed [cbr_pkg::DATA_W-1:0] b
    );
        logic signed [cbr_pkg::DATA_W:0] s;
        begin
            s = (cbr_pkg::DATA_W+1)'(a) + (cbr_pkg::DATA_W+1)'(b);
            return s[cbr_pkg::DATA_W:1];
        end
    endfunction

    logic signed [cbr_pkg::DATA_W-1:0] left_reg, left_next;
    logic signed [cbr_pkg::DATA_W-1:0] right_reg, right_next;
    logic signed [cbr_pkg::DATA_W-1:0] mid_reg, mid_next;
    logic signed [cbr_pkg::DATA_W-1:0] x_reg, x_next;
    cbr_pkg::sign_t                    ls_reg, ls_next;
    cbr_pkg::sign_t                    rs_reg, rs_next;
    logic [cbr_pkg::STEP_W-1:0]        step_reg, step_next;

    logic                              done_reg;
    logic signed [cbr_pkg::DATA_W-1:0] root_reg, fin_root;
    logic [1:0]                        status_reg, fin_status;
    logic [cbr_pkg::STEP_W-1:0]        steps_reg;

    logic signed [cbr_pkg::DATA_W:0]   width;
    logic                              narrow;
    logic                              swap;

    assign width  = (cbr_pkg::DATA_W+1)'(right_reg) - (cbr_pkg::DATA_W+1)'(left_reg);
    assign narrow = width < $signed({2'b00, tolerance});
    assign swap   = interval_low > interval_high;

    always_comb
    begin
        unique case (ctrl.x_op)
            cbr_pkg::X_KEEP:  x_next = x_reg;
            cbr_pkg::X_LEFT:  x_next = left_reg;
            cbr_pkg::X_RIGHT: x_next = right_reg;
            cbr_pkg::X_MID:   x_next = mid_reg;
            default:          x_next = x_reg;
        endcase
    end

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        mid_next   = mid_reg;
        ls_next    = ls_reg;
        rs_next    = rs_reg;
        step_next  = step_reg;
        done_req   = 1'b0;
        fin_root   = mid_reg;
        fin_status = cbr_pkg::ST_CONVERGED;
        if (accept)
        begin
            left_next  = swap ? interval_high : interval_low;
            right_next = swap ? interval_low : interval_high;
            mid_next   = mid_of(interval_low, interval_high);
            step_next  = '0;
        end
        else
        begin
            unique case (ctrl.op)
                cbr_pkg::T_NONE:
                begin
                end
                cbr_pkg::T_SIGN_LEFT:
                begin
                    ls_next = sign;
                end
                cbr_pkg::T_ENDS:
                begin
                    rs_next = sign;
                    priority if (ls_reg == cbr_pkg::SGN_ZERO)
                    begin
                        done_req   = 1'b1;
                        fin_root   = left_reg;
                        fin_status = cbr_pkg::ST_EXACT;
                    end
                    else if (sign == cbr_pkg::SGN_ZERO)
                    begin
                        done_req   = 1'b1;
                        fin_root   = right_reg;
                        fin_status = cbr_pkg::ST_EXACT;
                    end
                    else if (sign == ls_reg)
                    begin
                        done_req   = 1'b1;
                        fin_status = cbr_pkg::ST_NO_BRACKET;
                    end
                    else
                    begin
                        // bracketed: bisection goes on
                    end
                end
                cbr_pkg::T_LOOP:
                begin
                    priority if (narrow)
                    begin
                        done_req   = 1'b1;
                        fin_status = cbr_pkg::ST_CONVERGED;
                    end
                    else if (step_reg >= cbr_pkg::STEP_W'(cbr_pkg::MAX_STEPS))
                    begin
                        done_req   = 1'b1;
                        fin_status = cbr_pkg::ST_STEP_LIMIT;
                    end
                    else
                    begin
                        step_next = step_reg + cbr_pkg::STEP_W'(1);
                    end
                end
                cbr_pkg::T_MID:
                begin
                    priority if (sign == cbr_pkg::SGN_ZERO)
                    begin
                        done_req   = 1'b1;
                        fin_status = cbr_pkg::ST_EXACT;
                    end
                    else
                    begin
                        if (sign == ls_reg)
                        begin
                            left_next = mid_reg;
                        end
                        else
                        begin
                            right_next = mid_reg;
                        end
                        mid_next = mid_of(left_next, right_next);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            mid_reg    <= '0;
            x_reg      <= '0;
            ls_reg     <= cbr_pkg::SGN_ZERO;
            rs_reg     <= cbr_pkg::SGN_ZERO;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            root_reg   <= '0;
            status_reg <= cbr_pkg::ST_EXACT;
            steps_reg  <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            mid_reg   <= mid_next;
            x_reg     <= x_next;
            ls_reg    <= ls_next;
            rs_reg    <= rs_next;
            step_reg  <= step_next;
            done_reg  <= done_req;
            if (done_req)
            begin
                root_reg   <= fin_root;
                status_reg <= fin_status;
                steps_reg  <= step_reg;
            end
        end
    end

    assign x           = x_reg;
    assign done        = done_reg;
    assign root        = root_reg;
    assign status      = status_reg;
    assign steps_taken = steps_reg;

endmodule

FILE: rtl/cubic_bisection_root.sv
// cubic_bisection_root: top level, configuration registers and module wiring.
// Depends on cbr_pkg, cbr_sequencer, cbr_horner, cbr_bisect.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  item in  | start & !busy           | interval_low, interval_high
//  result   | done (one-cycle strobe) | root, status, steps_taken
//  config   | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// Each polynomial evaluation runs on the shared 33x32 multiplier as 10 microcode steps
// plus the calling step. An item evaluates both endpoints, then one midpoint per
// bisection step, up to 32 steps.
// The result strobe comes with busy already low; the next start may follow at once.
// Reset clears the sequencer to idle and the other registers, but not the Horner datapath, to their reset values.
// cfg_ready is always high; the receiver cannot stall results.
module cubic_bisection_root (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cbr_pkg::DATA_W-1:0] interval_low,
    input  logic signed [cbr_pkg::DATA_W-1:0] interval_high,
    output logic                              done,
    output logic signed [cbr_pkg::DATA_W-1:0] root,
    output logic [1:0]                        status,
    output logic [cbr_pkg::STEP_W-1:0]        steps_taken,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  cbr_pkg::reg_idx_t                 cfg_index,
    input  logic [cbr_pkg::DATA_W-1:0]        cfg_data
);

    cbr_pkg::coef_t                    coef_reg;
    logic [cbr_pkg::TOL_W-1:0]         tol_reg;
    cbr_pkg::ucode_t                   ctrl;
    cbr_pkg::sign_t                    sign;
    logic signed [cbr_pkg::DATA_W-1:0] x;
    logic                              accept;
    logic                              done_req;

    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            tol_reg  <= cbr_pkg::TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbr_pkg::REG_CUBIC:    coef_reg.c3 <= cfg_data;
                cbr_pkg::REG_SQUARE:   coef_reg.c2 <= cfg_data;
                cbr_pkg::REG_LINEAR:   coef_reg.c1 <= cfg_data;
                cbr_pkg::REG_CONSTANT: coef_reg.c0 <= cfg_data;
                cbr_pkg::REG_TOL:      tol_reg     <= cfg_data[cbr_pkg::TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cbr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .done_req (done_req),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    cbr_horner u_horner (
        .clk  (clk),
        .ctrl (ctrl),
        .coef (coef_reg),
        .x    (x),
        .sign (sign)
    );

    cbr_bisect u_bisect (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .interval_low  (interval_low),
        .interval_high (interval_high),
        .ctrl          (ctrl),
        .sign          (sign),
        .tolerance     (tol_reg),
        .x             (x),
        .done_req      (done_req),
        .done          (done),
        .root          (root),
        .status        (status),
        .steps_taken   (steps_taken)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start the sequencer");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> steps_taken <= cbr_pkg::STEP_W'(cbr_pkg::MAX_STEPS))
        else $error("step count beyond limit");

    a_no_bracket_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cbr_pkg::ST_NO_BRACKET) |-> steps_taken == '0)
        else $error("no-bracket result with bisection steps");

    a_limit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cbr_pkg::ST_STEP_LIMIT)
            |-> steps_taken == cbr_pkg::STEP_W'(cbr_pkg::MAX_STEPS))
        else $error("step-limit result below the limit");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for cubic_bisection_root, with its own bisection predictor.
// Depends on cbr_pkg and the cubic_bisection_root RTL; needs no other file.
module tb;
    import cbr_pkg::*;

    localparam int unsigned ITEM_TARGET = 2000;
    localparam int unsigned WATCHDOG    = 5000;
    localparam int unsigned TAIL        = 420;

    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] ONE   = 32'sh0001_0000;

    localparam reg_idx_t REG_SPARE_LO = REG_TOL + 3'd1;
    localparam reg_idx_t REG_SPARE_HI = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] root;
        logic [1:0]               status;
        logic [STEP_W-1:0]        steps;
    } root_beat_t;

    class root_tracker;
        logic signed [DATA_W-1:0] c_cubic;
        logic signed [DATA_W-1:0] c_square;
        logic signed [DATA_W-1:0] c_linear;
        logic signed [DATA_W-1:0] c_constant;
        logic [TOL_W-1:0]         tol;
        logic signed [DATA_W-1:0] lo_end;
        logic signed [DATA_W-1:0] hi_end;
        logic signed [DATA_W-1:0] mid_pt;
        sign_t                    lo_sign;
        sign_t                    hi_sign;
        logic [STEP_W-1:0]        halvings;
        root_beat_t               pending_roots[$];
        int unsigned              faults;
        int unsigned              checked;
        int unsigned              deepest;
        int unsigned              status_seen[4];

        function new();
            c_cubic    = '0;
            c_square   = '0;
            c_linear   = '0;
            c_constant = '0;
            tol        = TOL_RESET;
            lo_end     = '0;
            hi_end     = '0;
            mid_pt     = '0;
            lo_sign    = SGN_ZERO;
            hi_sign    = SGN_ZERO;
            halvings   = '0;
            faults     = 0;
            checked    = 0;
            deepest    = 0;
            for (int i = 0; i < 4; i++)
            begin
                status_seen[i] = 0;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_CUBIC:    c_cubic    = val;
                REG_SQUARE:   c_square   = val;
                REG_LINEAR:   c_linear   = val;
                REG_CONSTANT: c_constant = val;
                REG_TOL:      tol        = val[TOL_W-1:0];
                default:      ;
            endcase
        endfunction

        // exact Horner evaluation; 128 bits hold every intermediate without loss
        function sign_t poly_sign(logic signed [DATA_W-1:0] x);
            logic signed [WIDE_W-1:0] h;
            logic signed [WIDE_W-1:0] xw;
            logic signed [WIDE_W-1:0] term;
            xw   = x;
            h    = c_cubic;
            term = c_square;
            h    = h * xw + (term <<< FRAC_BITS);
            term = c_linear;
            h    = h * xw + (term <<< (2 * FRAC_BITS));
            term = c_constant;
            h    = h * xw + (term <<< (3 * FRAC_BITS));
            if (h < 0)
                return SGN_NEG;
            else if (h == 0)
                return SGN_ZERO;
            return SGN_POS;
        endfunction

        function logic signed [DATA_W-1:0] halfway(logic signed [DATA_W-1:0] a,
                                                   logic signed [DATA_W-1:0] b);
            logic signed [DATA_W:0] s;
            s = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
            return s[DATA_W:1];
        endfunction

        function root_beat_t bisect_interval(logic signed [DATA_W-1:0] lo,
                                             logic signed [DATA_W-1:0] hi);
            root_beat_t             r;
            logic signed [DATA_W:0] span;
            sign_t                  ms;
            bit                     fin;
            if (lo > hi)
            begin
                lo_end = hi;
                hi_end = lo;
            end
            else
            begin
                lo_end = lo;
                hi_end = hi;
            end
            halvings = '0;
            mid_pt   = halfway(lo_end, hi_end);
            lo_sign  = poly_sign(lo_end);
            hi_sign  = poly_sign(hi_end);
            if (lo_sign == SGN_ZERO)
            begin
                r.root   = lo_end;
                r.status = ST_EXACT;
            end
            else if (hi_sign == SGN_ZERO)
            begin
                r.root   = hi_end;
                r.status = ST_EXACT;
            end
            else if (lo_sign == hi_sign)
            begin
                r.root   = mid_pt;
                r.status = ST_NO_BRACKET;
            end
            else
            begin
                fin = 1'b0;
                while (!fin)
                begin
                    span = $signed({hi_end[DATA_W-1], hi_end}) -
                           $signed({lo_end[DATA_W-1], lo_end});
                    fin  = 1'b1;
                    r.root = mid_pt;
                    if (span < $signed({2'b00, tol}))
                        r.status = ST_CONVERGED;
                    else if (halvings >= MAX_STEPS)
                        r.status = ST_STEP_LIMIT;
                    else
                    begin
                        halvings = halvings + 1'b1;
                        ms = poly_sign(mid_pt);
                        if (ms == SGN_ZERO)
                            r.status = ST_EXACT;
                        else
                        begin
                            if (ms == lo_sign)
                                lo_end = mid_pt;
                            else
                                hi_end = mid_pt;
                            mid_pt = halfway(lo_end, hi_end);
                            fin    = 1'b0;
                        end
                    end
                end
            end
            r.steps = halvings;
            return r;
        endfunction

        function void note_interval(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
            pending_roots.push_back(bisect_interval(lo, hi));
        endfunction

        function void check_root(logic signed [DATA_W-1:0] got_root, logic [1:0] got_status,
                                 logic [STEP_W-1:0] got_steps);
            root_beat_t want;
            if (pending_roots.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result beat: root %h status %0d steps %0d",
                             got_root, got_status, got_steps);
                return;
            end
            want = pending_roots.pop_front();
            checked++;
            status_seen[want.status]++;
            if (want.steps > deepest)
                deepest = want.steps;
            if (want.root !== got_root || want.status !== got_status ||
                want.steps !== got_steps)
            begin
                faults++;
                if (faults <= 10)
                    $display("mismatch on result %0d: expected root %h status %0d steps %0d, got root %h status %0d steps %0d",
                             checked, want.root, want.status, want.steps,
                             got_root, got_status, got_steps);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] interval_low;
    logic signed [DATA_W-1:0] interval_high;
    logic                     done;
    logic signed [DATA_W-1:0] root;
    logic [1:0]               status;
    logic [STEP_W-1:0]        steps_taken;
    logic                     cfg_valid;
    logic                     cfg_ready;
    reg_idx_t                 cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    root_tracker sb;
    int unsigned items_in   = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_run   = 0;
    int unsigned phases     = 0;
    bit          calm       = 1'b0;
    bit          moved;

    cubic_bisection_root DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .interval_low  (interval_low),
        .interval_high (interval_high),
        .done          (done),
        .root          (root),
        .status        (status),
        .steps_taken   (steps_taken),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // DUT outputs update by NBA, so this block sees pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                sb.set_reg(cfg_index, cfg_data);
                cfg_writes++;
                moved = 1'b1;
            end
            if (done)
            begin
                sb.check_root(root, status, steps_taken);
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                sb.note_interval(interval_low, interval_high);
                items_in++;
                moved = 1'b1;
            end
            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= WATCHDOG)
            begin
                $display("watchdog: %0d cycles without a beat", idle_run);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp(logic signed [DATA_W:0] v);
        if (v > Q_MAX)
            return Q_MAX;
        else if (v < Q_MIN)
            return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_point();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            1, 2:    return $urandom;
            3, 4:    return (int'($urandom_range(0, 40)) - 20) * ONE;
            default: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic idle_for(int unsigned n);
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_interval(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
        int unsigned target;
        target = items_in + 1;
        start         <= 1'b1;
        interval_low  <= lo;
        interval_high <= hi;
        do
            @(negedge clk);
        while (items_in < target);
        idle_for(calm ? 0 : gap_len());
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
        int unsigned target;
        target = cfg_writes + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (cfg_writes < target);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_poly(logic signed [DATA_W-1:0] c3, logic signed [DATA_W-1:0] c2,
                             logic signed [DATA_W-1:0] c1, logic signed [DATA_W-1:0] c0,
                             logic [DATA_W-1:0] tol_data);
        write_reg(REG_CUBIC, c3);
        write_reg(REG_SQUARE, c2);
        write_reg(REG_LINEAR, c1);
        write_reg(REG_CONSTANT, c0);
        write_reg(REG_TOL, tol_data);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_roots.size() != 0 || busy);
    endtask

    // mostly intervals whose ends differ in sign, so the search runs deep
    task automatic pick_interval(output logic signed [DATA_W-1:0] lo,
                                 output logic signed [DATA_W-1:0] hi);
        logic signed [DATA_W:0]   c;
        logic signed [DATA_W:0]   d;
        logic signed [DATA_W-1:0] t;
        sign_t                    sl;
        sign_t                    sr;
        bit                       found;
        found = 1'b0;
        for (int tries = 0; tries < 8 && !found; tries++)
        begin
            if (tries < 5)
            begin
                c  = pick_point();
                d  = {1'b0, $urandom >> $urandom_range(1, 31)};
                lo = clamp(c - d);
                hi = clamp(c + d);
            end
            else
            begin
                lo = {1'b1, 31'($urandom)};
                hi = {1'b0, 31'($urandom)};
            end
            sl = sb.poly_sign(lo);
            sr = sb.poly_sign(hi);
            found = (sl != sr) || (sl == SGN_ZERO);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
    endtask

    task automatic choose_poly(output logic signed [DATA_W-1:0] c3,
                               output logic signed [DATA_W-1:0] c2,
                               output logic signed [DATA_W-1:0] c1,
                               output logic signed [DATA_W-1:0] c0);
        int r;
        c3 = '0;
        c2 = '0;
        c1 = '0;
        c0 = '0;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                c3 = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                c2 = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                c1 = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                c0 = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            end
            2:
            begin
                c3 = $urandom;
                c2 = $urandom;
                c1 = $urandom;
                c0 = $urandom;
            end
            3:
            begin
                c1 = int'($urandom_range(1, 32'h4_0000)) * ($urandom_range(0, 1) ? 1 : -1);
                c0 = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            end
            4:
            begin
                // x^3 - r^3 with integer r: exact zero at r
                r  = int'($urandom_range(0, 60)) - 30;
                c3 = ONE;
                c0 = -(r * r * r) * ONE;
            end
            default:
            begin
                c0 = $urandom_range(0, 1) ? '0 : $urandom;
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] choose_tol();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 1;
            2:       return TOL_RESET;
            3:       return {1'b0, {TOL_W{1'b1}}};
            4:       return $urandom;
            default: return $urandom_range(1, 32'h10_0000);
        endcase
    endfunction

    initial
    begin
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] c3;
        logic signed [DATA_W-1:0] c2;
        logic signed [DATA_W-1:0] c1;
        logic signed [DATA_W-1:0] c0;
        int unsigned              burst;
        int unsigned              leftover;

        sb            = new();
        rst_n         = 1'b0;
        start         = 1'b0;
        interval_low  = '0;
        interval_high = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CUBIC;
        cfg_data      = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients: f is zero everywhere
        send_interval('0, '0);
        send_interval(Q_MIN, Q_MAX);
        send_interval(Q_MAX, Q_MIN);
        drain();

        // f = x - 1
        load_poly('0, '0, ONE, -ONE, TOL_RESET);
        write_reg(REG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        phases++;
        send_interval('0, 2 * ONE);
        send_interval(ONE, 5 * ONE);
        send_interval(-3 * ONE, ONE);
        send_interval('0, 3 * ONE);
        send_interval(2 * ONE, 5 * ONE);
        send_interval(3 * ONE, '0);
        send_interval(Q_MIN, Q_MAX);
        send_interval(ONE - 100, ONE + 100);
        send_interval(-1, '0);
        drain();

        write_reg(REG_TOL, '0);
        send_interval('0, 3 * ONE);
        send_interval(Q_MIN, Q_MAX);
        drain();

        write_reg(REG_TOL, '1);
        send_interval(Q_MIN, Q_MAX);
        send_interval('0, 3 * ONE);
        drain();

        load_poly(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1);
        phases++;
        send_interval(Q_MIN, Q_MAX);
        send_interval(Q_MAX, Q_MIN);
        send_interval(-1, 1);
        send_interval('0, '0);
        send_interval(Q_MIN, Q_MIN);

        while (items_in < ITEM_TARGET)
        begin
            drain();
            choose_poly(c3, c2, c1, c0);
            load_poly(c3, c2, c1, c0, choose_tol());
            if ($urandom_range(0, 3) == 0)
                write_reg(reg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            phases++;
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(60, 180);
            for (int k = 0; k < burst && items_in < ITEM_TARGET; k++)
            begin
                if ($urandom_range(0, 4) != 0)
                    pick_interval(lo, hi);
                else
                begin
                    lo = pick_point();
                    hi = pick_point();
                end
                send_interval(lo, hi);
                if ($urandom_range(0, 119) == 0)
                    drain();
            end
        end

        drain();
        repeat (TAIL) @(negedge clk);
        leftover = sb.pending_roots.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("covered %0d intervals under %0d coefficient sets, %0d register writes",
                 items_in, phases, cfg_writes);
        $display("outcomes: %0d exact, %0d converged, %0d no bracket, %0d step limit; deepest %0d halvings, %0d faults",
                 sb.status_seen[ST_EXACT], sb.status_seen[ST_CONVERGED],
                 sb.status_seen[ST_NO_BRACKET], sb.status_seen[ST_STEP_LIMIT],
                 sb.deepest, sb.faults);
        if (sb.faults == 0 && leftover == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cbr_pkg.sv
rtl/cbr_sequencer.sv
rtl/cbr_horner.sv
rtl/cbr_bisect.sv
rtl/cubic_bisection_root.sv
tb/tb.sv
